// ===== rtl/efcd_pkg.sv =====
// Shared types and constants for the ECG falling-edge crossing detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package efcd_pkg;

	localparam int VALUE_W   = 10;
	localparam int TIME_W    = 16;
	localparam int WIN_W     = 8;
	localparam int CT_W      = 24;
	localparam int SLOT_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 10;

	localparam int MAX_CROSSINGS_DEF = 5;
	localparam int FRAC_BITS_DEF     = 8;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [VALUE_W-1:0] HIGH_LEVEL_RST     = 10'd1007;
	localparam logic [VALUE_W-1:0] LOW_LEVEL_RST      = 10'd16;
	localparam logic [VALUE_W-1:0] CROSSING_LEVEL_RST = 10'd511;
	localparam logic [WIN_W-1:0]   WINDOW_RST         = 8'd12;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CROSSING_LEVEL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW         = 2'd3;

	localparam logic KIND_RECORD   = 1'b0;
	localparam logic KIND_WITHDRAW = 1'b1;

	// One event handed from the classifier to the arithmetic back end.
	typedef struct packed {
		logic               kind;
		logic [SLOT_W-1:0]  slot;
		logic [SLOT_W-1:0]  count;
		logic [TIME_W-1:0]  t;
		logic [VALUE_W-1:0] num;
		logic [VALUE_W-1:0] dmag;
		logic               neg;
		logic               fault;
	} job_t;

endpackage
`default_nettype wire

// ===== rtl/efcd_front.sv =====
// Front end: configuration registers, the four-phase detection machine and
// event classification into jobs. Depends on efcd_pkg.
`default_nettype none
module efcd_front #(
	parameter int MAX_CROSSINGS = efcd_pkg::MAX_CROSSINGS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [efcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [efcd_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic [efcd_pkg::TIME_W-1:0]    sample_time,
	input  wire logic [efcd_pkg::VALUE_W-1:0]   sample_value,
	output      logic                           push_valid,
	input  wire logic                           push_ready,
	output      efcd_pkg::job_t                 push_job
);
	import efcd_pkg::*;

	localparam int CNT_W = $clog2(MAX_CROSSINGS + 1);

	typedef enum logic [1:0] {
		PH_WAIT_HIGH,
		PH_PEAK,
		PH_CROSS,
		PH_WAIT_LOW
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [VALUE_W-1:0] prev_q, prev_d;
	logic [TIME_W-1:0]  peak_q, peak_d;
	logic [VALUE_W-1:0] high_q, low_q, cross_q;
	logic [WIN_W-1:0]   window_q;

	logic               accept;
	logic               active;
	logic               timeout;
	logic [TIME_W-1:0]  elapsed;
	logic               neg;
	logic [VALUE_W-1:0] dmag;
	logic               emit;
	job_t               job;

	assign in_stall = !push_ready;
	assign accept   = in_valid && !in_stall;
	assign active   = count_q < CNT_W'(MAX_CROSSINGS);
	assign elapsed  = sample_time - peak_q;
	assign timeout  = elapsed > TIME_W'(window_q);
	assign neg      = prev_q < sample_value;
	assign dmag     = neg ? (sample_value - prev_q) : (prev_q - sample_value);

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		prev_d    = prev_q;
		peak_d    = peak_q;
		emit      = 1'b0;
		job.kind  = KIND_RECORD;
		job.slot  = SLOT_W'(count_q);
		job.count = SLOT_W'(count_q + 1'b1);
		job.t     = sample_time;
		job.num   = cross_q - sample_value;
		job.dmag  = dmag;
		job.neg   = neg;
		job.fault = (dmag == '0);
		case (phase_q)
			PH_WAIT_HIGH: begin
				if (sample_value >= high_q) begin
					prev_d  = sample_value;
					phase_d = PH_PEAK;
				end
			end
			PH_PEAK: begin
				if (sample_value < prev_q) begin
					peak_d  = sample_time - 1'b1;
					phase_d = PH_CROSS;
				end
				prev_d = sample_value;
			end
			PH_CROSS: begin
				if (timeout) begin
					phase_d = PH_WAIT_HIGH;
				end else begin
					prev_d = sample_value;
					if (sample_value < cross_q) begin
						emit    = 1'b1;
						count_d = count_q + 1'b1;
						phase_d = PH_WAIT_LOW;
					end
				end
			end
			PH_WAIT_LOW: begin
				if (timeout) begin
					phase_d = PH_WAIT_HIGH;
					if (count_q != '0) begin
						count_d = count_q - 1'b1;
					end
					emit      = 1'b1;
					job.kind  = KIND_WITHDRAW;
					job.slot  = SLOT_W'(count_d);
					job.count = SLOT_W'(count_d);
					job.fault = 1'b0;
				end else if (sample_value <= low_q) begin
					phase_d = PH_WAIT_HIGH;
				end
			end
			default: begin
				phase_d = PH_WAIT_HIGH;
			end
		endcase
	end

	assign push_valid = accept && active && emit;
	assign push_job   = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT_HIGH;
			count_q  <= '0;
			prev_q   <= '0;
			peak_q   <= '0;
			high_q   <= HIGH_LEVEL_RST;
			low_q    <= LOW_LEVEL_RST;
			cross_q  <= CROSSING_LEVEL_RST;
			window_q <= WINDOW_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HIGH_LEVEL:     high_q   <= cfg_data;
					REG_LOW_LEVEL:      low_q    <= cfg_data;
					REG_CROSSING_LEVEL: cross_q  <= cfg_data;
					REG_WINDOW:         window_q <= cfg_data[WIN_W-1:0];
					default: ;
				endcase
			end
			// Once the list is full every sample is dropped without effect.
			if (accept && active) begin
				phase_q <= phase_d;
				count_q <= count_d;
				prev_q  <= prev_d;
				peak_q  <= peak_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/efcd_queue.sv =====
// Small job queue between the classifier and the arithmetic back end.
// Depends on efcd_pkg for the job type.
`default_nettype none
module efcd_queue #(
	parameter int DEPTH = efcd_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output      logic           push_ready,
	input  wire efcd_pkg::job_t push_job,
	output      logic           pop_valid,
	input  wire logic           pop_ready,
	output      efcd_pkg::job_t pop_job
);
	import efcd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push, do_pop;

	assign push_ready = fill_q != CNT_W'(DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_job    = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/efcd_back.sv =====
// Back end: restoring divider for the interpolation, crossing time assembly
// and the output register. Depends on efcd_pkg.
`default_nettype none
module efcd_back #(
	parameter int FRAC_BITS = efcd_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          job_valid,
	output      logic                          job_pop,
	input  wire efcd_pkg::job_t                job,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic                          event_kind,
	output      logic [efcd_pkg::SLOT_W-1:0]   slot,
	output      logic [efcd_pkg::CT_W-1:0]     crossing_time,
	output      logic                          divide_fault,
	output      logic [efcd_pkg::SLOT_W-1:0]   crossing_count
);
	import efcd_pkg::*;

	localparam int DVD_W  = VALUE_W + FRAC_BITS;
	localparam int STEP_W = $clog2(DVD_W + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t             state_q;
	job_t               job_q;
	logic [VALUE_W-1:0] rem_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [STEP_W-1:0]  step_q;
	logic [CT_W-1:0]    last_q;
	logic               out_valid_q;

	logic [VALUE_W:0]   trial;
	logic               fits;
	logic [VALUE_W-1:0] rem_next;
	logic [CT_W-1:0]    t_fix;
	logic [CT_W-1:0]    mag;
	logic [CT_W-1:0]    cross_time;
	logic               out_free;

	assign job_pop  = (state_q == ST_IDLE) && job_valid;
	assign out_free = !out_valid_q || !out_stall;

	// One quotient bit per cycle; the remainder stays below a nonzero divisor.
	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign fits     = trial >= {1'b0, job_q.dmag};
	assign rem_next = fits ? VALUE_W'(trial - {1'b0, job_q.dmag}) : trial[VALUE_W-1:0];

	assign t_fix      = CT_W'({job_q.t, {FRAC_BITS{1'b0}}});
	assign mag        = job_q.fault ? '0 : CT_W'(dvd_q);
	assign cross_time = job_q.neg ? (t_fix + mag) : (t_fix - mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			last_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						rem_q   <= '0;
						dvd_q   <= {job.num, {FRAC_BITS{1'b0}}};
						step_q  <= STEP_W'(DVD_W);
						state_q <= (job.kind == KIND_RECORD) ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_next;
					dvd_q  <= {dvd_q[DVD_W-2:0], fits};
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						event_kind     <= job_q.kind;
						slot           <= job_q.slot;
						divide_fault   <= job_q.fault;
						crossing_count <= job_q.count;
						if (job_q.kind == KIND_RECORD) begin
							crossing_time <= cross_time;
							last_q        <= cross_time;
						end else begin
							crossing_time <= last_q;
						end
						state_q <= ST_IDLE;
					end else if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/ecg_falling_edge_crossing_detector.sv =====
// Top level of the ECG falling-edge crossing detector.
// Depends on efcd_pkg, efcd_front, efcd_queue and efcd_back.
// Usage: samples arrive on the input channel (in_valid/in_stall with
// sample_time and sample_value); events leave on the output channel
// (out_valid/out_stall with event_kind, slot, crossing_time, divide_fault
// and crossing_count). Thresholds and the timeout window are written
// through cfg_we/cfg_index/cfg_data while the block is idle.
// The front end takes one sample per cycle while in_stall is low. Most
// samples cause no event. An event becomes a job in a two-entry queue;
// in_stall rises only while that queue is full.
// A recorded crossing is interpolated by a restoring divider that produces
// one quotient bit per cycle; the back end takes the job from the queue in
// its idle state, divides, and in the done state loads the event into the
// output register. A withdrawal needs no division and skips the divide state.
// If the receiver holds out_stall, the finished event stays in the output
// register, the back end waits, and the queue absorbs up to two more events
// before the input is stalled.
// Reset restores the register defaults, clears the crossing list and puts
// the machine back to waiting for a high sample.
`default_nettype none
module ecg_falling_edge_crossing_detector #(
	parameter int MAX_CROSSINGS = efcd_pkg::MAX_CROSSINGS_DEF,
	parameter int FRAC_BITS     = efcd_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [efcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [efcd_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic [efcd_pkg::TIME_W-1:0]    sample_time,
	input  wire logic [efcd_pkg::VALUE_W-1:0]   sample_value,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic                           event_kind,
	output      logic [efcd_pkg::SLOT_W-1:0]    slot,
	output      logic [efcd_pkg::CT_W-1:0]      crossing_time,
	output      logic                           divide_fault,
	output      logic [efcd_pkg::SLOT_W-1:0]    crossing_count
);
	import efcd_pkg::*;

	logic push_valid, push_ready;
	job_t push_job;
	logic pop_valid, pop_ready;
	job_t pop_job;

	efcd_front #(
		.MAX_CROSSINGS(MAX_CROSSINGS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_time (sample_time),
		.sample_value(sample_value),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_job    (push_job)
	);

	efcd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job)
	);

	efcd_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (pop_valid),
		.job_pop       (pop_ready),
		.job           (pop_job),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.slot          (slot),
		.crossing_time (crossing_time),
		.divide_fault  (divide_fault),
		.crossing_count(crossing_count)
	);

	// A withdrawal never reports a divide fault.
	a_withdraw_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == KIND_WITHDRAW) |-> !divide_fault)
		else $error("withdrawal event carries a divide fault");

	// A recorded crossing sits just below the new count.
	a_record_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == KIND_RECORD) |->
		(crossing_count == SLOT_W'(slot + 1'b1)))
		else $error("recorded crossing slot does not match count");

	// A withdrawn crossing takes the slot freed by the decrement.
	a_withdraw_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == KIND_WITHDRAW) |-> (crossing_count == slot))
		else $error("withdrawn crossing slot does not match count");

	// The back end only takes a job when one is queued.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready |-> pop_valid)
		else $error("job taken from an empty queue");

endmodule
`default_nettype wire
